// ===== rtl/core/ssk_pkg.sv =====
package ssk_pkg;

    localparam int VALUE_W     = 16;
    localparam int TARGET_W    = 25;
    localparam int MATCH_W     = 9;
    localparam int TOTAL_W     = 16;
    localparam int MAX_LEN_DEF = 256;

    localparam logic [MATCH_W-1:0] MATCH_MAX = {MATCH_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      is_last;
    } in_item_t;

    typedef struct packed {
        logic [MATCH_W-1:0] match_count;
        logic [TOTAL_W-1:0] running_total;
        logic               done_res;
        logic               overflow;
    } out_item_t;

    // control bits that travel with each query token along the cell row
    typedef struct packed {
        logic valid;
        logic last;
        logic ovf;
    } tok_ctrl_t;

endpackage

// ===== rtl/core/ssk_front.sv =====
module ssk_front
    import ssk_pkg::*;
#(
    parameter int DEPTH  = MAX_LEN_DEF + 1,
    parameter int FILL_W = $clog2(MAX_LEN_DEF + 2),
    parameter int PW     = VALUE_W + $clog2(MAX_LEN_DEF),
    parameter int WW     = ((PW > TARGET_W) ? PW : TARGET_W) + 1
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  in_item_t                   in_data,
    input  logic signed [TARGET_W-1:0] target,
    input  logic                       adv,
    input  logic                       flush,
    output logic                       wr_en,
    output logic [FILL_W-1:0]          wr_idx,
    output logic signed [PW-1:0]       wr_data,
    output tok_ctrl_t                  tok_ctrl,
    output logic [FILL_W-1:0]          tok_fill,
    output logic signed [WW-1:0]       tok_want
);

    logic signed [PW-1:0] prefix_reg, prefix_next;
    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic                 ovf_reg, ovf_next;
    logic                 drain_reg, drain_next;
    tok_ctrl_t            ctrl_reg, ctrl_next;
    logic [FILL_W-1:0]    tfill_reg, tfill_next;
    logic signed [WW-1:0] want_reg, want_next;

    logic                 accept;
    logic                 full;
    logic signed [PW-1:0] pfx_sum;

    assign in_ready = adv && !drain_reg;
    assign accept   = in_valid && in_ready;
    assign full     = ovf_reg || (fill_reg == FILL_W'(DEPTH));
    assign pfx_sum  = prefix_reg + PW'(in_data.value);

    assign wr_en   = accept && !full;
    assign wr_idx  = fill_reg;
    assign wr_data = pfx_sum;

    always_comb
    begin
        prefix_next = prefix_reg;
        fill_next   = fill_reg;
        ovf_next    = ovf_reg;
        drain_next  = drain_reg;
        ctrl_next   = ctrl_reg;
        tfill_next  = tfill_reg;
        want_next   = want_reg;
        if (adv)
        begin
            ctrl_next  = '0;
            tfill_next = full ? '0 : fill_reg;
            want_next  = WW'(pfx_sum) - WW'(target);
            if (accept)
            begin
                ctrl_next.valid = 1'b1;
                ctrl_next.last  = in_data.is_last;
                ctrl_next.ovf   = full;
            end
        end
        if (accept)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                prefix_next = pfx_sum;
                fill_next   = fill_reg + FILL_W'(1);
            end
            if (in_data.is_last)
            begin
                prefix_next = '0;
                fill_next   = FILL_W'(1);
                ovf_next    = 1'b0;
                drain_next  = 1'b1;
            end
        end
        // the last element has left the cell row: the store may be refilled
        if (flush)
        begin
            drain_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg <= '0;
            fill_reg   <= FILL_W'(1);
            ovf_reg    <= 1'b0;
            drain_reg  <= 1'b0;
            ctrl_reg   <= '0;
        end
        else
        begin
            prefix_reg <= prefix_next;
            fill_reg   <= fill_next;
            ovf_reg    <= ovf_next;
            drain_reg  <= drain_next;
            ctrl_reg   <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tfill_reg <= tfill_next;
        want_reg  <= want_next;
    end

    assign tok_ctrl = ctrl_reg;
    assign tok_fill = tfill_reg;
    assign tok_want = want_reg;

endmodule

// ===== rtl/core/ssk_cell.sv =====
module ssk_cell
    import ssk_pkg::*;
#(
    parameter int IDX    = 0,
    parameter int FILL_W = $clog2(MAX_LEN_DEF + 2),
    parameter int PW     = VALUE_W + $clog2(MAX_LEN_DEF),
    parameter int WW     = ((PW > TARGET_W) ? PW : TARGET_W) + 1,
    parameter int CNT_W  = MATCH_W
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 wr_en,
    input  logic [FILL_W-1:0]    wr_idx,
    input  logic signed [PW-1:0] wr_data,
    input  tok_ctrl_t            in_ctrl,
    input  logic [FILL_W-1:0]    in_fill,
    input  logic signed [WW-1:0] in_want,
    input  logic [CNT_W-1:0]     in_count,
    output tok_ctrl_t            out_ctrl,
    output logic [FILL_W-1:0]    out_fill,
    output logic signed [WW-1:0] out_want,
    output logic [CNT_W-1:0]     out_count
);

    logic signed [PW-1:0] stored_reg, stored_next;
    tok_ctrl_t            ctrl_reg;
    logic [FILL_W-1:0]    fill_reg;
    logic signed [WW-1:0] want_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 hit;

    // the entry counts only for tokens that came after it was written
    assign hit = (FILL_W'(IDX) < in_fill) && (WW'(stored_reg) == in_want);

    assign stored_next = (wr_en && (wr_idx == FILL_W'(IDX))) ? wr_data : stored_reg;
    assign count_next  = in_count + CNT_W'(hit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_reg <= '0;
            ctrl_reg   <= '0;
        end
        else
        begin
            stored_reg <= stored_next;
            if (adv)
            begin
                ctrl_reg <= in_ctrl;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fill_reg  <= in_fill;
            want_reg  <= in_want;
            count_reg <= count_next;
        end
    end

    assign out_ctrl  = ctrl_reg;
    assign out_fill  = fill_reg;
    assign out_want  = want_reg;
    assign out_count = count_reg;

endmodule

// ===== rtl/core/ssk_tail.sv =====
module ssk_tail
    import ssk_pkg::*;
#(
    parameter int CNT_W = MATCH_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  tok_ctrl_t        in_ctrl,
    input  logic [CNT_W-1:0] in_count,
    output logic             adv,
    output logic             out_valid,
    input  logic             out_ready,
    output out_item_t        out_data
);

    localparam int SW = ((CNT_W > TOTAL_W) ? CNT_W : TOTAL_W) + 1;

    logic [TOTAL_W-1:0] total_reg, total_next;
    logic               valid_reg, valid_next;
    out_item_t          data_reg, data_next;
    logic [SW-1:0]      sum;
    logic [TOTAL_W-1:0] total_sat;

    assign adv       = !valid_reg || out_ready;
    assign sum       = SW'(total_reg) + SW'(in_count);
    assign total_sat = (sum > SW'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];

    always_comb
    begin
        total_next = total_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        if (adv)
        begin
            valid_next = in_ctrl.valid;
            if (in_ctrl.valid)
            begin
                if (!in_ctrl.ovf)
                begin
                    total_next = total_sat;
                end
                data_next.match_count   = (in_count > CNT_W'(MATCH_MAX)) ?
                                          MATCH_MAX : in_count[MATCH_W-1:0];
                data_next.running_total = in_ctrl.ovf ? total_reg : total_sat;
                data_next.done_res      = in_ctrl.last;
                data_next.overflow      = in_ctrl.ovf;
                if (in_ctrl.last)
                begin
                    total_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            total_reg <= total_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/core/subarray_sum_equals_k_counter_unit.sv =====
// Path: the front registers each query token; it passes every cell into the output register.
// Throughput: one element per cycle within an array while the row advances; the query token
// walks the row of MAX_LEN+1 cells, one cell per cycle while the row advances. After an
// element flagged last, in_ready stays low until that element leaves the cell row. Any cycle in
// which a held result waits on out_ready freezes the whole row and holds in_ready low.
// Reset (rst_n, asynchronous, active low): target 0, store holds only the seed zero,
// accumulators cleared, no transaction in flight. No clearing pass.
module subarray_sum_equals_k_counter_unit
    import ssk_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  in_item_t                   in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output out_item_t                  out_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic signed [TARGET_W-1:0] cfg_data
);

    // store entries: the seed zero plus one per element
    localparam int DEPTH  = MAX_LEN + 1;
    // fill level must be able to hold DEPTH itself to flag a full store
    localparam int FILL_W = $clog2(DEPTH + 1);
    // prefix sums of MAX_LEN full-scale elements fit exactly
    localparam int PW     = VALUE_W + $clog2(MAX_LEN);
    // width of prefix minus target
    localparam int WW     = ((PW > TARGET_W) ? PW : TARGET_W) + 1;
    // per-element count, never narrower than the reported field
    localparam int CNT_W  = ($clog2(MAX_LEN + 1) > MATCH_W) ? $clog2(MAX_LEN + 1) : MATCH_W;

    logic signed [TARGET_W-1:0] target_reg;

    logic                 adv;
    logic                 flush;
    logic                 wr_en;
    logic [FILL_W-1:0]    wr_idx;
    logic signed [PW-1:0] wr_data;

    // token row: element i feeds cell i, element DEPTH feeds the output stage
    tok_ctrl_t            ch_ctrl  [DEPTH+1];
    logic [FILL_W-1:0]    ch_fill  [DEPTH+1];
    logic signed [WW-1:0] ch_want  [DEPTH+1];
    logic [CNT_W-1:0]     ch_count [DEPTH+1];

    // configuration: always take the write; the block is idle by contract
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            target_reg <= cfg_data;
        end
    end

    // front: advance the prefix sum, write the new entry, launch the query token
    ssk_front #(
        .DEPTH  (DEPTH),
        .FILL_W (FILL_W),
        .PW     (PW),
        .WW     (WW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .target   (target_reg),
        .adv      (adv),
        .flush    (flush),
        .wr_en    (wr_en),
        .wr_idx   (wr_idx),
        .wr_data  (wr_data),
        .tok_ctrl (ch_ctrl[0]),
        .tok_fill (ch_fill[0]),
        .tok_want (ch_want[0])
    );

    assign ch_count[0] = '0;

    // row of cells: each holds one stored prefix sum and adds its hit to the passing token
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        ssk_cell #(
            .IDX    (i),
            .FILL_W (FILL_W),
            .PW     (PW),
            .WW     (WW),
            .CNT_W  (CNT_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .wr_en     (wr_en),
            .wr_idx    (wr_idx),
            .wr_data   (wr_data),
            .in_ctrl   (ch_ctrl[i]),
            .in_fill   (ch_fill[i]),
            .in_want   (ch_want[i]),
            .in_count  (ch_count[i]),
            .out_ctrl  (ch_ctrl[i+1]),
            .out_fill  (ch_fill[i+1]),
            .out_want  (ch_want[i+1]),
            .out_count (ch_count[i+1])
        );
    end

    // release the input once the last element of an array drops out of the row
    assign flush = adv && ch_ctrl[DEPTH].valid && ch_ctrl[DEPTH].last;

    // output stage: running total and the result register; it also paces the whole row
    ssk_tail #(
        .CNT_W (CNT_W)
    ) u_tail (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ctrl   (ch_ctrl[DEPTH]),
        .in_count  (ch_count[DEPTH]),
        .adv       (adv),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // a new entry never lands on the seed entry or past the store
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (wr_idx != '0) && (wr_idx < FILL_W'(DEPTH)))
        else $error("store write outside the valid entry range");

    // after the last element of an array the input must hold until the row drains
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_data.is_last) |=> !in_ready)
        else $error("input taken while the previous array is still draining");

    // a dropped element reports no matches
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.overflow) |-> (out_data.match_count == '0))
        else $error("overflow result carries a nonzero match count");

    // a result is only produced from a token that really left the row
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv && !ch_ctrl[DEPTH].valid) |=> !out_valid)
        else $error("output valid without a token from the cell row");

endmodule
